// ===== design/braking_speed_limiter_assert.svh =====
// ----------------------------------------------------------------------------
// Braking speed limiter assertion macros
// Shared concurrent assertion forms; the including scope provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef BRAKING_SPEED_LIMITER_ASSERT_SVH
`define BRAKING_SPEED_LIMITER_ASSERT_SVH

// Check a same-cycle implication
`define BSL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("braking_speed_limiter: same-cycle check failed");

// Check an implication in the next cycle
`define BSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("braking_speed_limiter: next-cycle check failed");

`endif

// ===== design/bsl_pkg.sv =====
// ----------------------------------------------------------------------------
// Braking speed limiter package
// Widths, reset constants and the sideband record carried down the pipeline.
// ----------------------------------------------------------------------------
package bsl_pkg;

  // Q16.16 word and deceleration register widths
  localparam int unsigned Q_W     = 32;
  localparam int unsigned DECEL_W = 31;

  // 2*a*|e| and v*v both stay below 2^63
  localparam int unsigned PROD_W = 63;

  // Square root: radicand padded to an even width, 32-bit root
  localparam int unsigned RAD_W  = 64;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned REM_W  = ROOT_W + 1;

  localparam logic [DECEL_W-1:0] DECEL_RESET = 31'd65536;

  // Root digits resolved per pipeline stage (must divide ROOT_W)
  localparam int unsigned ROOT_STEPS_DEFAULT = 2;

  // Per-transaction sideband that rides along with the radicand
  typedef struct packed {
    logic           limit;    // braking distance reached
    logic [Q_W-1:0] req_abs;  // request magnitude, 2^31 for the most negative
    logic [Q_W-1:0] req_raw;  // request as received
  } side_t;

endpackage

// ===== design/bsl_root_pipe.sv =====
// ----------------------------------------------------------------------------
// Braking speed limiter square root pipeline
// Digit-by-digit floor square root, STEPS_PER_STAGE root bits per stage.
// ----------------------------------------------------------------------------
module bsl_root_pipe #(
  parameter int unsigned STEPS_PER_STAGE = bsl_pkg::ROOT_STEPS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic                       in_valid,
  input  logic [bsl_pkg::RAD_W-1:0]  in_rad,
  input  bsl_pkg::side_t             in_side,
  output logic                       out_valid,
  output logic [bsl_pkg::ROOT_W-1:0] out_root,
  output bsl_pkg::side_t             out_side
);
  import bsl_pkg::*;

  localparam int unsigned STAGES = ROOT_W / STEPS_PER_STAGE;

  // Stage outputs, one entry per stage
  logic              stage_valid [STAGES];
  logic [RAD_W-1:0]  stage_rad   [STAGES];
  logic [REM_W-1:0]  stage_rem   [STAGES];
  logic [ROOT_W-1:0] stage_root  [STAGES];
  side_t             stage_side  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic              valid_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    side_t             side_in;
    logic [RAD_W-1:0]  rad_nxt;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;
    logic              valid_r;
    logic [RAD_W-1:0]  rad_r;
    logic [REM_W-1:0]  rem_r;
    logic [ROOT_W-1:0] root_r;
    side_t             side_r;

    // Select the stage input: pipeline entry or previous stage
    if (s == 0) begin : g_head
      assign valid_in = in_valid;
      assign rad_in   = in_rad;
      assign rem_in   = '0;
      assign root_in  = '0;
      assign side_in  = in_side;
    end else begin : g_link
      assign valid_in = stage_valid[s-1];
      assign rad_in   = stage_rad[s-1];
      assign rem_in   = stage_rem[s-1];
      assign root_in  = stage_root[s-1];
      assign side_in  = stage_side[s-1];
    end

    // Resolve the next root bits: shift in a radicand pair, trial subtract
    always_comb begin
      logic [REM_W+1:0] rem_sh;
      logic [REM_W+1:0] trial;
      rad_nxt  = rad_in;
      rem_nxt  = rem_in;
      root_nxt = root_in;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        rem_sh  = {rem_nxt, rad_nxt[RAD_W-1 -: 2]};
        rad_nxt = {rad_nxt[RAD_W-3:0], 2'b00};
        trial   = {1'b0, root_nxt, 2'b01};
        if (rem_sh >= trial) begin
          rem_sh   = rem_sh - trial;
          root_nxt = {root_nxt[ROOT_W-2:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[ROOT_W-2:0], 1'b0};
        end
        rem_nxt = rem_sh[REM_W-1:0];
      end
    end

    // Advance the valid bit with the pipeline
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r <= 1'b0;
      end else if (advance) begin
        valid_r <= valid_in;
      end
    end

    // Advance the payload
    always_ff @(posedge clk) begin
      if (advance) begin
        rad_r  <= rad_nxt;
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        side_r <= side_in;
      end
    end

    assign stage_valid[s] = valid_r;
    assign stage_rad[s]   = rad_r;
    assign stage_rem[s]   = rem_r;
    assign stage_root[s]  = root_r;
    assign stage_side[s]  = side_r;
  end

  assign out_valid = stage_valid[STAGES-1];
  assign out_root  = stage_root[STAGES-1];
  assign out_side  = stage_side[STAGES-1];

endmodule

// ===== design/braking_speed_limiter.sv =====
// ----------------------------------------------------------------------------
// Braking speed limiter
// Limits a Q16.16 speed order to the square-root deceleration profile: when
// 2*a*|error| <= v*v the order magnitude is capped at floor(sqrt(2*a*|error|)),
// keeping the order's sign; otherwise the order passes unchanged. The block
// takes one transaction per clock while in_stall is low and has no state
// between transactions, so several axes may share it. An accepted
// transaction passes through the magnitude stage, one stage for the two
// multiplies, one for the distance compare, the square root pipeline at
// ROOT_STEPS_PER_STAGE (two by default) root bits per stage, and the output
// register. The output has a one-entry skid buffer; in_stall rises only
// while that buffer holds a transaction. decel_rate resets to 1.0.
// ----------------------------------------------------------------------------
module braking_speed_limiter #(
  parameter int unsigned ROOT_STEPS_PER_STAGE = bsl_pkg::ROOT_STEPS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [bsl_pkg::Q_W-1:0]     in_distance_error,
  input  logic signed [bsl_pkg::Q_W-1:0]     in_measured_speed,
  input  logic signed [bsl_pkg::Q_W-1:0]     in_speed_request,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [bsl_pkg::Q_W-1:0]     out_speed_limited,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic        [bsl_pkg::DECEL_W-1:0] cfg_decel_rate
);
  import bsl_pkg::*;

  // Magnitude of a two's complement word; the most negative value gives 2^31
  function automatic logic [Q_W-1:0] mag32(input logic [Q_W-1:0] x);
    mag32 = x[Q_W-1] ? (~x + 1'b1) : x;
  endfunction

  logic               advance;
  logic [DECEL_W-1:0] decel_r;

  logic               s1_valid_r;
  logic [DECEL_W-1:0] s1_a_r;
  logic [Q_W-1:0]     s1_e_r;
  logic [Q_W-1:0]     s1_v_r;
  side_t              s1_side_r;

  logic [PROD_W-1:0]  prod_ae;
  logic [2*Q_W-1:0]   prod_vv;
  logic               s2_valid_r;
  logic [PROD_W-1:0]  s2_two_ae_r;
  logic [PROD_W-1:0]  s2_vsq_r;
  side_t              s2_side_r;

  logic               s3_valid_r;
  logic [RAD_W-1:0]   s3_rad_r;
  side_t              s3_side_r;
  side_t              s3_side_nxt;

  logic               tail_valid;
  logic [ROOT_W-1:0]  tail_root;
  side_t              tail_side;
  logic [Q_W-1:0]     tail_result;

  logic               out_take;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [Q_W-1:0]     out_data_r;
  logic [Q_W-1:0]     out_data_nxt;
  logic               skid_valid_r;
  logic               skid_valid_nxt;
  logic [Q_W-1:0]     skid_data_r;
  logic [Q_W-1:0]     skid_data_nxt;

  // Freeze the pipeline while the skid buffer is occupied
  assign advance  = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // Hold the deceleration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decel_r <= DECEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      decel_r <= cfg_decel_rate;
    end
  end

  // Stage 1: take magnitudes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_a_r            <= decel_r;
      s1_e_r            <= mag32(in_distance_error);
      s1_v_r            <= mag32(in_measured_speed);
      s1_side_r.limit   <= 1'b0;
      s1_side_r.req_abs <= mag32(in_speed_request);
      s1_side_r.req_raw <= in_speed_request;
    end
  end

  // Stage 2: form 2*a*|e| and v*v
  assign prod_ae = {{(PROD_W-DECEL_W){1'b0}}, s1_a_r} * {{(PROD_W-Q_W){1'b0}}, s1_e_r};
  assign prod_vv = {{Q_W{1'b0}}, s1_v_r} * {{Q_W{1'b0}}, s1_v_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_two_ae_r <= {prod_ae[PROD_W-2:0], 1'b0};
      s2_vsq_r    <= prod_vv[PROD_W-1:0];
      s2_side_r   <= s1_side_r;
    end
  end

  // Stage 3: compare the braking distance with the remaining distance
  always_comb begin
    s3_side_nxt       = s2_side_r;
    s3_side_nxt.limit = (s2_two_ae_r <= s2_vsq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (advance) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_rad_r  <= {{(RAD_W-PROD_W){1'b0}}, s2_two_ae_r};
      s3_side_r <= s3_side_nxt;
    end
  end

  // Square root of 2*a*|e|
  bsl_root_pipe #(
    .STEPS_PER_STAGE (ROOT_STEPS_PER_STAGE)
  ) u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .in_valid  (s3_valid_r),
    .in_rad    (s3_rad_r),
    .in_side   (s3_side_r),
    .out_valid (tail_valid),
    .out_root  (tail_root),
    .out_side  (tail_side)
  );

  // Replace the order when the distance limit is reached and the braking speed is below its magnitude
  always_comb begin
    tail_result = tail_side.req_raw;
    if (tail_side.limit && (tail_root < tail_side.req_abs)) begin
      tail_result = tail_side.req_raw[Q_W-1] ? (~tail_root + 1'b1) : tail_root;
    end
  end

  // Output register with one-entry skid buffer
  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (tail_valid) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = tail_result;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = tail_result;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_speed_limited = out_data_r;

endmodule

// ===== design/bsl_checker.sv =====
// ----------------------------------------------------------------------------
// Braking speed limiter port checker
// Watches the handshake ports of the top level and the skid buffer behavior.
// ----------------------------------------------------------------------------
`include "braking_speed_limiter_assert.svh"

module bsl_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [bsl_pkg::Q_W-1:0]        out_speed_limited
);

  // Hold a stalled result transaction
  `BSL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_speed_limited))

  // Stall the input only after a stalled result
  `BSL_ASSERT_NOW(a_stall_cause, in_stall, $past(out_valid && out_stall))

  // Stall the input only while a result waits
  `BSL_ASSERT_NOW(a_stall_backed, in_stall, out_valid)

  // Release the input in the cycle after the result side frees up
  `BSL_ASSERT_NEXT(a_stall_release, in_stall && !(out_valid && out_stall), !in_stall)

endmodule

bind braking_speed_limiter bsl_checker u_bsl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_speed_limited (out_speed_limited)
);
